// ----- design/vaf_pkg.sv -----
// vaf_pkg: shared constants, types and cordic helpers for view_angle_fov_top
// no dependencies; imported by view_angle_fov_top and its checker
`default_nettype none

package vaf_pkg;

  // cordic micro-rotations per vectoring unit
  localparam int CORDIC_STEPS = 20;

  // cordic datapath widths: vector components and angle accumulator (2^-24 degree)
  localparam int CW = 40;
  localparam int AW = 36;

  // stage map of the pipeline
  localparam int ST_IN    = 0;
  localparam int ST_NORM  = 1;
  localparam int ST_PREP  = 2;
  localparam int ST_YAW0  = 3;
  localparam int ST_PPREP = ST_YAW0 + CORDIC_STEPS;
  localparam int ST_PIT0  = ST_PPREP + 1;
  localparam int ST_POST1 = ST_PIT0 + CORDIC_STEPS;
  localparam int ST_POST2 = ST_POST1 + 1;
  localparam int ST_OUT   = ST_POST2 + 1;
  localparam int NSTAGE   = ST_OUT + 1;

  // field layout of the stream words
  localparam int IN_TDATA_W  = 232;
  localparam int OUT_TDATA_W = 88;

  localparam logic [14:0] PITCH_LIMIT_RST = 15'd22784;

  localparam logic signed [AW-1:0] ANG_HALF_TURN = 36'sd3019898880;
  localparam logic signed [25:0]   GAIN_Q24      = 26'sd27628053;
  localparam logic signed [19:0]   DEG90         = 20'sd23040;
  localparam logic signed [19:0]   DEG360        = 20'sd92160;

  localparam logic signed [AW-1:0] ATAN_TAB [32] = '{
    36'sd754974720, 36'sd445687602, 36'sd235489088, 36'sd119537938,
    36'sd60000934,  36'sd30029717,  36'sd15018523,  36'sd7509720,
    36'sd3754917,   36'sd1877466,   36'sd938734,    36'sd469367,
    36'sd234684,    36'sd117342,    36'sd58671,     36'sd29335,
    36'sd14668,     36'sd7334,      36'sd3667,      36'sd1833,
    36'sd917,       36'sd458,       36'sd229,       36'sd115,
    36'sd57,        36'sd29,        36'sd14,        36'sd7,
    36'sd4,         36'sd2,         36'sd1,         36'sd0
  };

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] z;
  } cordic_t;

  // values that ride along with the cordic vector
  typedef struct packed {
    logic signed [15:0]   vp;
    logic signed [16:0]   vy;
    logic                 zero_xy;
    logic                 zero_all;
    logic signed [CW-1:0] pk;
    logic signed [16:0]   yaw;
  } side_t;

  // one vectoring micro-rotation; i is a constant at every call site
  function automatic cordic_t cordic_step(cordic_t c, int unsigned i);
    cordic_t r;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    xs = c.x >>> i;
    ys = c.y >>> i;
    if (c.y > 0) begin
      r.x = c.x + ys;
      r.y = c.y - xs;
      r.z = c.z + ATAN_TAB[i[4:0]];
    end else begin
      r.x = c.x - ys;
      r.y = c.y + xs;
      r.z = c.z - ATAN_TAB[i[4:0]];
    end
    return r;
  endfunction

  // 2^-24 degree to 1/256 degree, round half up
  function automatic logic signed [19:0] to_units(logic signed [AW-1:0] a);
    logic signed [AW-1:0] t;
    t = a + 36'sd32768;
    return t[AW-1:16];
  endfunction

endpackage

`default_nettype wire

// ----- design/view_angle_fov_top.sv -----
// view_angle_fov_top: aim pitch/yaw toward a target and angular distance to the view
// depends on vaf_pkg (constants, cordic step, types)
//
//  channel   | dir | handshake          | word
//  ----------+-----+--------------------+-------------------------------------------
//  s_*       | in  | s_tvalid/s_tready  | view angles, eye and target position
//  m_*       | out | m_tvalid/m_tready  | aim pitch/yaw, pitch/yaw diff, fov
//  cfg_*     | in  | cfg_wen            | pitch_limit, 15 bits, no read-back
//
// one word in and one out per cycle while m_tready does not stall the output
// the two chained 20-step cordic vectoring units set the depth, one step per stage
// every stage has its own valid bit; a stage loads when empty or when the one
// after it moves, so bubbles close up and a stalled output holds its word
// rst is synchronous; it clears all valid bits and restores pitch_limit to 22784
`default_nettype none

module view_angle_fov_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // view_pitch[15:0] view_yaw[32:16] eye_x[64:33] eye_y[96:65] eye_z[128:97]
  // target_x[160:129] target_y[192:161] target_z[224:193], zero pad to 232
  input  wire logic [vaf_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // aim_pitch[15:0] aim_yaw[32:16] pitch_diff[48:33] yaw_diff[65:49]
  // fov[82:66], zero pad to 88
  output logic [vaf_pkg::OUT_TDATA_W-1:0]         m_tdata,
  input  wire logic                               cfg_wen,
  input  wire logic [14:0]                        cfg_wdata
);
  import vaf_pkg::*;

  logic [14:0] pitch_limit;

  // stage valid bits and load enables
  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] en;

  always_comb begin
    en[NSTAGE-1] = !vld[NSTAGE-1] || m_tready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign s_tready = en[ST_IN];
  assign m_tvalid = vld[ST_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_limit <= PITCH_LIMIT_RST;
    end else if (cfg_wen) begin
      pitch_limit <= cfg_wdata;
    end
  end

  // ---------------- input stage: target minus eye ----------------
  logic signed [15:0] in_vp;
  logic signed [16:0] in_vy;
  logic signed [32:0] in_dx, in_dy, in_dz;

  always_ff @(posedge clk) begin
    if (en[ST_IN]) begin
      in_vp <= s_tdata[15:0];
      in_vy <= s_tdata[32:16];
      in_dx <= {s_tdata[160], s_tdata[160:129]} - {s_tdata[64], s_tdata[64:33]};
      in_dy <= {s_tdata[192], s_tdata[192:161]} - {s_tdata[96], s_tdata[96:65]};
      in_dz <= {s_tdata[224], s_tdata[224:193]} - {s_tdata[128], s_tdata[128:97]};
    end
  end

  // ---------------- normalize: largest magnitude into [2^32, 2^33) ----------------
  logic [31:0]        ax, ay, az, mx;
  logic [5:0]         blen, sh;
  logic signed [65:0] tx, ty, tz;

  always_comb begin
    ax = in_dx[32] ? 32'(-in_dx) : in_dx[31:0];
    ay = in_dy[32] ? 32'(-in_dy) : in_dy[31:0];
    az = in_dz[32] ? 32'(-in_dz) : in_dz[31:0];
    mx = ax;
    if (ay > mx) mx = ay;
    if (az > mx) mx = az;
    blen = '0;
    for (int b = 0; b < 32; b++) begin
      if (mx[b]) blen = 6'(b + 1);
    end
    sh = 6'd33 - blen;
    tx = 66'(in_dx) <<< sh;
    ty = 66'(in_dy) <<< sh;
    tz = 66'(in_dz) <<< sh;
  end

  logic signed [33:0] n_sx, n_sy, n_sz;
  side_t              n_side;

  always_ff @(posedge clk) begin
    if (en[ST_NORM]) begin
      n_sx             <= tx[33:0];
      n_sy             <= ty[33:0];
      n_sz             <= tz[33:0];
      n_side.vp        <= in_vp;
      n_side.vy        <= in_vy;
      n_side.zero_xy   <= (in_dx == '0) && (in_dy == '0);
      n_side.zero_all  <= (in_dx == '0) && (in_dy == '0) && (in_dz == '0);
      n_side.pk        <= '0;
      n_side.yaw       <= '0;
    end
  end

  // ---------------- prep: left half-plane fold, gain multiply for pitch ----------------
  cordic_t            p_c;
  logic signed [59:0] p_prod;
  side_t              p_side;
  cordic_t            prep_c;

  always_comb begin
    if (n_sx < 0) begin
      prep_c.x = -CW'(n_sx);
      prep_c.y = -CW'(n_sy);
      prep_c.z = (n_sy >= 0) ? ANG_HALF_TURN : -ANG_HALF_TURN;
    end else begin
      prep_c.x = CW'(n_sx);
      prep_c.y = CW'(n_sy);
      prep_c.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_PREP]) begin
      p_c    <= prep_c;
      p_prod <= 60'(n_sz) * 60'(GAIN_Q24);
      p_side <= n_side;
    end
  end

  // ---------------- yaw cordic, one micro-rotation per stage ----------------
  cordic_t yc [CORDIC_STEPS];
  side_t   ys [CORDIC_STEPS];

  logic signed [59:0] neg_prod;
  side_t              ys0_side;

  assign neg_prod = -p_prod;

  always_comb begin
    ys0_side    = p_side;
    // scaled -dz, floored shift of the gain product
    ys0_side.pk = {{(CW-36){neg_prod[59]}}, neg_prod[59:24]};
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_yaw
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[ST_YAW0]) begin
          yc[0] <= cordic_step(p_c, 0);
          ys[0] <= ys0_side;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (en[ST_YAW0+k]) begin
          yc[k] <= cordic_step(yc[k-1], k);
          ys[k] <= ys[k-1];
        end
      end
    end
  end

  // ---------------- pitch prep: yaw in units, start pitch vector ----------------
  logic signed [19:0] yaw_u;
  cordic_t            pp_c;
  side_t              pp_side;
  side_t              pp_side_next;

  assign yaw_u = to_units(yc[CORDIC_STEPS-1].z);

  always_comb begin
    pp_side_next     = ys[CORDIC_STEPS-1];
    pp_side_next.yaw = ys[CORDIC_STEPS-1].zero_xy ? '0 : yaw_u[16:0];
  end

  always_ff @(posedge clk) begin
    if (en[ST_PPREP]) begin
      pp_c.x  <= ys[CORDIC_STEPS-1].zero_xy ? '0 : yc[CORDIC_STEPS-1].x;
      pp_c.y  <= ys[CORDIC_STEPS-1].pk;
      pp_c.z  <= '0;
      pp_side <= pp_side_next;
    end
  end

  // ---------------- pitch cordic ----------------
  cordic_t pc [CORDIC_STEPS];
  side_t   ps [CORDIC_STEPS];

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_pitch
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[ST_PIT0]) begin
          pc[0] <= cordic_step(pp_c, 0);
          ps[0] <= pp_side;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (en[ST_PIT0+k]) begin
          pc[k] <= cordic_step(pc[k-1], k);
          ps[k] <= ps[k-1];
        end
      end
    end
  end

  // ---------------- post 1: pitch in units ----------------
  logic signed [19:0] q1_pitch;
  side_t              q1_side;

  always_ff @(posedge clk) begin
    if (en[ST_POST1]) begin
      q1_pitch <= ps[CORDIC_STEPS-1].zero_all ? '0 : to_units(pc[CORDIC_STEPS-1].z);
      q1_side  <= ps[CORDIC_STEPS-1];
    end
  end

  // ---------------- post 2: clamp, yaw difference with opposing-pole wrap ----------------
  logic signed [19:0] lim, clamp_p, vy20, yw20, yd_raw;
  logic signed [15:0] q2_pitch;
  logic [19:0]        q2_yd;
  side_t              q2_side;

  always_comb begin
    lim     = 20'($signed({1'b0, pitch_limit}));
    clamp_p = q1_pitch;
    if (clamp_p > lim)  clamp_p = lim;
    if (clamp_p < -lim) clamp_p = -lim;
    vy20 = 20'(q1_side.vy);
    yw20 = 20'(q1_side.yaw);
    if (vy20 < -DEG90 && yw20 > DEG90) begin
      yd_raw = vy20 + DEG360 - yw20;
    end else if (vy20 > DEG90 && yw20 < -DEG90) begin
      yd_raw = yw20 + DEG360 - vy20;
    end else begin
      yd_raw = vy20 - yw20;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_POST2]) begin
      q2_pitch <= clamp_p[15:0];
      q2_yd    <= yd_raw[19] ? 20'(-yd_raw) : 20'(yd_raw);
      q2_side  <= q1_side;
    end
  end

  // ---------------- output stage: pitch difference and fov ----------------
  logic signed [16:0] pd_raw;
  logic [19:0]        pd_abs, fov_full;

  always_comb begin
    pd_raw   = 17'(q2_side.vp) - 17'(q2_pitch);
    pd_abs   = pd_raw[16] ? 20'(-pd_raw) : 20'(pd_raw);
    fov_full = (pd_abs > q2_yd) ? pd_abs : q2_yd;
  end

  logic [15:0] o_pitch, o_pd;
  logic [16:0] o_yaw, o_yd, o_fov;

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      o_pitch <= q2_pitch;
      o_yaw   <= q2_side.yaw;
      o_pd    <= pd_abs[15:0];
      o_yd    <= q2_yd[16:0];
      o_fov   <= fov_full[16:0];
    end
  end

  assign m_tdata = {5'b0, o_fov, o_yd, o_pd, o_yaw, o_pitch};

endmodule

`default_nettype wire

// ----- design/vaf_check.sv -----
// vaf_check: port-level assertions for view_angle_fov_top
// bound to view_angle_fov_top below; uses vaf_pkg for the word width
`default_nettype none

module vaf_check (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_tready,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [vaf_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import vaf_pkg::*;

  // a stalled output word stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed under stall");

  // reset empties the pipeline
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // input backpressure only when the output end is full
  a_bp: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with empty output");

  // fov is one of the two differences
  a_fov: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[82:66] == {1'b0, m_tdata[48:33]}) ||
                 (m_tdata[82:66] == m_tdata[65:49]))
    else $error("fov is neither difference");

endmodule

bind view_angle_fov_top vaf_check u_vaf_check (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
